FILE: rtl/core/varint_length_prefixed_deframer_macros.svh
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_macros
// Assertion macros for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VLPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared types and constants of the varint length-prefixed deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

	localparam logic [15:0] LIMIT_RESET = 16'd16384;
	localparam int          QUEUE_DEPTH = 2;

	// One classified byte, handed from the front end to the output side.
	typedef struct packed {
		logic [7:0]  data;       // payload byte, zero when has_data is low
		logic [31:0] id_raw;     // raw id varint, used when set_id is high
		logic        set_id;     // id varint completed on this byte
		logic        emit;       // this entry produces a result transfer
		logic        has_data;
		logic        last;
		logic        truncated;
		logic        malformed;
	} entry_t;

endpackage

FILE: rtl/core/vlpd_front.sv
// ----------------------------------------------------------------------------
// vlpd_front
// Framing state machine: decodes the length and id varints, tracks frame
// position against the byte limit and classifies each accepted byte.
// ----------------------------------------------------------------------------
module vlpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	output logic                  push,
	output vlpd_pkg::entry_t      push_entry
);

	localparam logic [1:0] PH_LEN     = 2'd0;
	localparam logic [1:0] PH_ID      = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [2:0] VARINT_MAX = 3'd5;
	localparam logic [16:0] COUNT_SAT = 17'h1FFFF;

	logic [15:0] max_q;
	logic [1:0]  phase_q;
	logic [31:0] acc_q;
	logic [2:0]  vcnt_q;
	logic [31:0] rem_q;
	logic [16:0] fcnt_q;
	logic        ovf_q;

	logic [38:0] shifted;
	logic [31:0] acc_or;
	logic [2:0]  vcnt_inc;
	logic        vdone;
	logic        kept;
	logic        ovf_nxt;
	logic [31:0] rem_dec;
	logic        clear;
	logic [1:0]  phase_nxt;
	logic [31:0] acc_nxt;
	logic [2:0]  vcnt_nxt;
	logic [31:0] rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= vlpd_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// Group k of a varint lands at bit 7k; bits beyond 32 fall off.
	always_comb begin
		case (vcnt_q)
			3'd0:    shifted = {32'd0, data_byte[6:0]};
			3'd1:    shifted = {25'd0, data_byte[6:0], 7'd0};
			3'd2:    shifted = {18'd0, data_byte[6:0], 14'd0};
			3'd3:    shifted = {11'd0, data_byte[6:0], 21'd0};
			3'd4:    shifted = {4'd0, data_byte[6:0], 28'd0};
			default: shifted = '0;
		endcase
	end

	assign acc_or   = acc_q | shifted[31:0];
	assign vcnt_inc = vcnt_q + 3'd1;
	assign vdone    = !data_byte[7] || (vcnt_inc >= VARINT_MAX);
	assign kept     = fcnt_q < {1'b0, max_q};
	assign ovf_nxt  = ovf_q | ~kept;
	assign rem_dec  = rem_q - 32'd1;

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		clear      = 1'b0;
		phase_nxt  = phase_q;
		acc_nxt    = acc_or;
		vcnt_nxt   = vcnt_inc;
		rem_nxt    = rem_q;
		unique case (phase_q)
			PH_ID: begin
				rem_nxt = rem_dec;
				if (vdone) begin
					acc_nxt  = '0;
					vcnt_nxt = '0;
					push     = 1'b1;
					push_entry.set_id = 1'b1;
					push_entry.id_raw = acc_or;
					if (rem_dec == '0) begin
						push_entry.emit      = 1'b1;
						push_entry.last      = 1'b1;
						push_entry.truncated = ovf_nxt;
						clear                = 1'b1;
					end else begin
						phase_nxt = PH_PAYLOAD;
					end
				end else if (rem_dec == '0) begin
					// frame ran out inside the id varint
					push                 = 1'b1;
					push_entry.emit      = 1'b1;
					push_entry.last      = 1'b1;
					push_entry.truncated = ovf_nxt;
					push_entry.malformed = 1'b1;
					clear                = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				acc_nxt  = acc_q;
				vcnt_nxt = vcnt_q;
				rem_nxt  = rem_dec;
				if (kept || rem_dec == '0) begin
					push                = 1'b1;
					push_entry.emit     = 1'b1;
					push_entry.has_data = kept;
					push_entry.data     = kept ? data_byte : 8'd0;
					if (rem_dec == '0) begin
						push_entry.last      = 1'b1;
						push_entry.truncated = ovf_nxt;
						clear                = 1'b1;
					end
				end
			end
			default: begin
				// length prefix; the unused phase code lands here too
				phase_nxt = PH_LEN;
				if (vdone) begin
					acc_nxt  = '0;
					vcnt_nxt = '0;
					rem_nxt  = acc_or;
					if (acc_or == '0) begin
						push                 = 1'b1;
						push_entry.emit      = 1'b1;
						push_entry.last      = 1'b1;
						push_entry.truncated = ovf_nxt;
						push_entry.malformed = 1'b1;
						clear                = 1'b1;
					end else begin
						phase_nxt = PH_ID;
					end
				end
			end
		endcase
		push = push & take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			acc_q   <= '0;
			vcnt_q  <= '0;
			rem_q   <= '0;
			fcnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (clear) begin
				phase_q <= PH_LEN;
				acc_q   <= '0;
				vcnt_q  <= '0;
				rem_q   <= '0;
				fcnt_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_nxt;
				acc_q   <= acc_nxt;
				vcnt_q  <= vcnt_nxt;
				rem_q   <= rem_nxt;
				fcnt_q  <= (fcnt_q == COUNT_SAT) ? fcnt_q : fcnt_q + 17'd1;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

FILE: rtl/core/vlpd_queue.sv
// ----------------------------------------------------------------------------
// vlpd_queue
// Two-entry queue between the front end and the output side.
// ----------------------------------------------------------------------------
module vlpd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vlpd_pkg::entry_t      push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output vlpd_pkg::entry_t      head_entry
);

	localparam int PTR_W = $clog2(vlpd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(vlpd_pkg::QUEUE_DEPTH + 1);

	vlpd_pkg::entry_t slot_q [vlpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(vlpd_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(vlpd_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(vlpd_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/vlpd_back.sv
// ----------------------------------------------------------------------------
// vlpd_back
// Output side: reduces the id modulo 255, holds the frame id and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module vlpd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  vlpd_pkg::entry_t      head_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            payload_byte,
	output logic [7:0]            packet_id,
	output logic                  has_data,
	output logic                  last,
	output logic                  truncated,
	output logic                  malformed
);

	logic [7:0] id_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic [7:0] pid_q;
	logic       has_q;
	logic       last_q;
	logic       trunc_q;
	logic       bad_q;

	logic [9:0] byte_sum;
	logic [8:0] fold;
	logic [7:0] id_mod;
	logic [7:0] id_sel;

	// 256 = 1 mod 255, so the residue is the byte sum folded once more.
	assign byte_sum = {2'b0, head_entry.id_raw[7:0]} + {2'b0, head_entry.id_raw[15:8]}
	                + {2'b0, head_entry.id_raw[23:16]} + {2'b0, head_entry.id_raw[31:24]};
	assign fold     = {1'b0, byte_sum[7:0]} + {7'd0, byte_sum[9:8]};
	assign id_mod   = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
	assign id_sel   = head_entry.malformed ? 8'd0 : (head_entry.set_id ? id_mod : id_q);

	assign pop = head_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (pop && head_entry.set_id) begin
			id_q <= id_mod;
		end
		if (pop && head_entry.emit) begin
			data_q  <= head_entry.data;
			pid_q   <= id_sel;
			has_q   <= head_entry.has_data;
			last_q  <= head_entry.last;
			trunc_q <= head_entry.truncated;
			bad_q   <= head_entry.malformed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && head_entry.emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = data_q;
	assign packet_id    = pid_q;
	assign has_data     = has_q;
	assign last         = last_q;
	assign truncated    = trunc_q;
	assign malformed    = bad_q;

endmodule

FILE: rtl/core/varint_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer
// Splits a byte stream into varint length-prefixed frames and emits their
// payload bytes tagged with the packet id modulo 255.
// ----------------------------------------------------------------------------
// Takes one byte per clock, sustained, as long as out_stall stays low. Each
// byte updates the framing state machine (varint shift/or, 32-bit
// remaining-length decrement, limit compare); its classified result enters
// a two-entry queue at the byte transfer, moves into the output register
// when that is empty or not stalled and transfers from there. in_stall
// rises only when the queue is full, so a stalled output blocks input once
// the output register and both queue entries are occupied. Bytes that
// produce no result (prefix bytes, id bytes, dropped payload bytes) never
// reach the output. max_frame_bytes is written through cfg_wr_en/cfg_wr_data;
// the user writes it only while idle; the block itself does not enforce that.
module varint_length_prefixed_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic [7:0]  packet_id,
	output logic        has_data,
	output logic        last,
	output logic        truncated,
	output logic        malformed
);

	logic             take;
	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	vlpd_pkg::entry_t push_entry;
	vlpd_pkg::entry_t head_entry;

	assign in_stall = full;
	assign take     = in_valid && !full;

	vlpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.take       (take),
		.data_byte  (data_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	vlpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	vlpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_byte(payload_byte),
		.packet_id   (packet_id),
		.has_data    (has_data),
		.last        (last),
		.truncated   (truncated),
		.malformed   (malformed)
	);

endmodule

FILE: rtl/core/vlpd_checker.sv
// ----------------------------------------------------------------------------
// vlpd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`include "varint_length_prefixed_deframer_macros.svh"

module vlpd_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] payload_byte,
	input  logic [7:0] packet_id,
	input  logic       has_data,
	input  logic       last,
	input  logic       truncated,
	input  logic       malformed
);

	`VLPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
	`VLPD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(payload_byte) && $stable(packet_id) && $stable(has_data) && $stable(last) && $stable(truncated) && $stable(malformed), "result changed while stalled")
	`VLPD_ASSERT_NOW(a_bad_form, clk, arst_n, out_valid && malformed, last && !has_data && packet_id == 8'd0, "malformed result not an empty last transfer")
	`VLPD_ASSERT_NOW(a_trunc_last, clk, arst_n, out_valid && truncated, last, "truncated flag on a non-last transfer")
	`VLPD_ASSERT_NOW(a_id_range, clk, arst_n, out_valid, packet_id != 8'hFF, "packet id not reduced modulo 255")

endmodule

bind varint_length_prefixed_deframer vlpd_checker u_vlpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.payload_byte(payload_byte),
	.packet_id   (packet_id),
	.has_data    (has_data),
	.last        (last),
	.truncated   (truncated),
	.malformed   (malformed)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the varint length-prefixed deframer.
// Drives special frames, buffer-limit corner cases and ~1100 bytes of random
// framed traffic through valid/stall channels, predicts every result transfer
// with an in-bench frame decoder and compares field by field in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int          CLK_HALF      = 6;
	localparam int          RESET_CYCLES  = 11;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          RANDOM_BYTES  = 1100;
	localparam int          VARINT_MAX    = 5;
	localparam int          SETTLE_CYCLES = 6;
	localparam logic [31:0] ID_MODULUS    = 32'd255;
	localparam logic [16:0] COUNT_SAT     = 17'h1FFFF;

	typedef enum logic [1:0] {PH_LENGTH, PH_ID, PH_PAYLOAD} frame_phase_t;
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] packet_id;
		logic       has_data;
		logic       last;
		logic       truncated;
		logic       malformed;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic [7:0]  packet_id;
	logic        has_data;
	logic        last;
	logic        truncated;
	logic        malformed;

	varint_length_prefixed_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.packet_id    (packet_id),
		.has_data     (has_data),
		.last         (last),
		.truncated    (truncated),
		.malformed    (malformed)
	);

	always #(CLK_HALF) clk = ~clk;

	// decoder state mirrored by the bench
	frame_phase_t ph;
	logic [31:0]  vacc;
	logic [2:0]   vcnt;
	logic [31:0]  remaining;
	logic [16:0]  fcount;
	logic [7:0]   cur_id;
	logic         ovf;
	logic [15:0]  limit_q;

	frame_result_t due_results[$];
	logic [7:0]    tx_bytes[$];

	int          err_count = 0;
	int          cycle_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	int          stall_cycle = 0;
	int          stall_hold = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic        stall_next;

	function automatic void clear_frame();
		ph = PH_LENGTH;
		vacc = '0;
		vcnt = '0;
		remaining = '0;
		fcount = '0;
		cur_id = '0;
		ovf = 1'b0;
	endfunction

	// returns 1 when the varint is complete; the fifth byte always ends it
	function automatic bit varint_take(input logic [7:0] b);
		int shift;
		shift = 7 * int'(vcnt);
		if (shift < 32)
			vacc = vacc | (32'(b[6:0]) << shift);
		vcnt = vcnt + 3'd1;
		return !b[7] || int'(vcnt) >= VARINT_MAX;
	endfunction

	function automatic void push_result(input logic [7:0] d, input logic [7:0] id,
			input logic has, input logic lst, input logic trunc, input logic bad);
		frame_result_t r;
		r.payload_byte = d;
		r.packet_id = id;
		r.has_data = has;
		r.last = lst;
		r.truncated = trunc;
		r.malformed = bad;
		due_results.push_back(r);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic kept;
		logic lst;
		kept = fcount < 17'(limit_q);
		if (!kept)
			ovf = 1'b1;
		if (fcount != COUNT_SAT)
			fcount = fcount + 17'd1;
		case (ph)
			PH_ID: begin
				remaining = remaining - 32'd1;
				if (varint_take(b)) begin
					cur_id = 8'(vacc % ID_MODULUS);
					vacc = '0;
					vcnt = '0;
					if (remaining == 0) begin
						push_result(8'h00, cur_id, 1'b0, 1'b1, ovf, 1'b0);
						clear_frame();
					end else begin
						ph = PH_PAYLOAD;
					end
				end else if (remaining == 0) begin
					// frame ran out inside the id
					push_result(8'h00, 8'h00, 1'b0, 1'b1, ovf, 1'b1);
					clear_frame();
				end
			end
			PH_PAYLOAD: begin
				remaining = remaining - 32'd1;
				lst = remaining == 0;
				// a dropped final byte still closes the frame
				if (kept || lst)
					push_result(kept ? b : 8'h00, cur_id, kept, lst, lst ? ovf : 1'b0, 1'b0);
				if (lst)
					clear_frame();
			end
			default: begin
				ph = PH_LENGTH;
				if (varint_take(b)) begin
					remaining = vacc;
					vacc = '0;
					vcnt = '0;
					if (remaining == 0) begin
						push_result(8'h00, 8'h00, 1'b0, 1'b1, ovf, 1'b1);
						clear_frame();
					end else begin
						ph = PH_ID;
					end
				end
			end
		endcase
	endfunction

	function automatic int varint_len(input logic [31:0] v);
		int n;
		n = 1;
		while (n < VARINT_MAX && (v >> (7 * n)) != 0)
			n++;
		return n;
	endfunction

	// nbytes above the minimum gives a non-canonical encoding
	function automatic void put_varint(input logic [31:0] v, input int nbytes,
			input bit long_tail);
		logic [31:0] grp;
		logic [7:0]  b;
		for (int i = 0; i < nbytes; i++) begin
			grp = v >> (7 * i);
			b = {1'b0, grp[6:0]};
			if (i < nbytes - 1)
				b[7] = 1'b1;
			if (i == VARINT_MAX - 1) begin
				// bits past 32 are dropped by the decoder
				b[6:4] = 3'($urandom);
				if (long_tail)
					b[7] = 1'b1;
			end
			tx_bytes.push_back(b);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		bit took;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_queued();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// body_len < 0 keeps the natural length; pre_n 0 means minimal prefix
	task automatic send_frame(input logic [31:0] id_val, input int id_n, input int pay_n,
			input int body_len, input int pre_n, input bit long_pre, input bit long_id);
		int start;
		if (long_id || id_n > VARINT_MAX)
			id_n = VARINT_MAX;
		if (id_n < varint_len(id_val))
			id_n = varint_len(id_val);
		if (body_len < 0)
			body_len = id_n + pay_n;
		if (pre_n > VARINT_MAX)
			pre_n = VARINT_MAX;
		if (pre_n < varint_len(body_len))
			pre_n = varint_len(body_len);
		put_varint(body_len, pre_n, long_pre && pre_n == VARINT_MAX);
		start = tx_bytes.size();
		put_varint(id_val, id_n, long_id);
		repeat (pay_n) tx_bytes.push_back(8'($urandom));
		while (tx_bytes.size() > start + body_len)
			void'(tx_bytes.pop_back());
		send_queued();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		// id and prefix bytes may still be in flight with nothing expected
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_q = v;
	endtask

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return vlpd_pkg::LIMIT_RESET;
			4, 5: return 16'($urandom_range(2, 24));
			6: return 16'($urandom_range(25, 80));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_frame();
		logic [31:0] id_val;
		int sel;
		int id_n;
		int pay_n;
		int pre_n;
		int n;
		sel = $urandom_range(99);
		case ($urandom_range(3))
			0: id_val = $urandom_range(300);
			1: id_val = $urandom;
			2: id_val = 32'hFFFF_FFFF - $urandom_range(300);
			default: id_val = 32'd254 + $urandom_range(1);
		endcase
		id_n = ($urandom_range(9) == 0) ? $urandom_range(1, VARINT_MAX) : 0;
		pre_n = ($urandom_range(6) == 0) ? $urandom_range(1, VARINT_MAX) : 0;
		n = $urandom_range(19);
		if (n < 14)
			pay_n = $urandom_range(10);
		else if (n < 19)
			pay_n = $urandom_range(11, 40);
		else
			pay_n = $urandom_range(41, 200);
		if (sel < 80) begin
			send_frame(id_val, id_n, pay_n, -1, pre_n, $urandom_range(1),
				$urandom_range(11) == 0);
		end else if (sel < 88) begin
			// frame ends inside the id varint
			id_n = $urandom_range(2, VARINT_MAX);
			if (id_n < varint_len(id_val))
				id_n = varint_len(id_val);
			if (id_n < 2)
				id_n = 2;
			send_frame(id_val, id_n, 0, $urandom_range(1, id_n - 1), pre_n, $urandom_range(1),
				1'b0);
		end else if (sel < 92) begin
			send_frame(id_val, 0, 0, 0, pre_n, $urandom_range(1), 1'b0);
		end else begin
			// random body bytes behind a sane length
			n = $urandom_range(1, 8);
			put_varint(n, 1, 1'b0);
			repeat (n) tx_bytes.push_back(8'($urandom));
			send_queued();
		end
	endtask

	task automatic test_special_frames();
		tx_bytes = {8'h00,                                    // zero length
			8'h02, 8'hFE, 8'h01,                              // id-only, id 254
			8'h04, 8'hFF, 8'h01, 8'h00, 8'hFF,                // id 255, byte extremes
			8'h01, 8'h80,                                     // id unfinished
			8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7F,         // 5-byte prefix, bit 7 set
			8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55,  // 5-byte id, all ones
			8'h82, 8'h00, 8'h05, 8'hAA};                      // non-canonical prefix
		send_queued();
	endtask

	task automatic test_limit_edges();
		set_limit(16'd0);
		tx_bytes = {8'h02, 8'h07, 8'hAA, 8'h00};
		send_queued();
		set_limit(16'd1);
		tx_bytes = {8'h03, 8'h09, 8'h11, 8'h22};
		send_queued();
		set_limit(16'd3);
		tx_bytes = {8'h04, 8'h09, 8'h11, 8'h22, 8'h33};
		send_queued();
		set_limit(16'd2);
		tx_bytes = {8'h83, 8'h00, 8'h09, 8'h11, 8'h22};
		send_queued();
		set_limit(16'hFFFF);
		send_frame(32'd77, 0, 30, -1, 0, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int first;
		int next_change;
		first = bytes_sent;
		next_change = bytes_sent + 150;
		while (bytes_sent - first < RANDOM_BYTES) begin
			if (bytes_sent >= next_change) begin
				set_limit(pick_limit());
				gaps_on = $urandom_range(3) != 0;
				next_change = bytes_sent + $urandom_range(80, 200);
			end else if ($urandom_range(39) == 0) begin
				wait_idle();
			end
			random_frame();
		end
	endtask

	initial begin
		limit_q = vlpd_pkg::LIMIT_RESET;
		clear_frame();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_frames();
		test_limit_edges();
		test_random_traffic();
		wait_idle();
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		stall_cycle++;
		if (stall_cycle % 97 == 0)
			stall_mode = stall_mode_t'($urandom_range(3));
		case (stall_mode)
			STALL_NONE: stall_next = 1'b0;
			STALL_RANDOM: stall_next = $urandom_range(3) == 0;
			STALL_PERIODIC: stall_next = (stall_cycle % 7) < 3;
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					stall_next = 1'b1;
				end else begin
					stall_next = 1'b0;
					if ($urandom_range(9) == 0)
						stall_hold = $urandom_range(5, 15);
				end
			end
		endcase
		out_stall <= stall_next;
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// outputs only change at the rising edge, so the value seen here is the transfer
	always @(negedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_results.size() == 0) begin
				err_count++;
				$display("%0t: result expected none actual id %0h byte %0h", $time,
					packet_id, payload_byte);
			end else begin
				want = due_results.pop_front();
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("packet_id", want.packet_id, packet_id);
				check_field("has_data", 8'(want.has_data), 8'(has_data));
				check_field("last", 8'(want.last), 8'(last));
				check_field("truncated", 8'(want.truncated), 8'(truncated));
				check_field("malformed", 8'(want.malformed), 8'(malformed));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/vlpd_pkg.sv
rtl/core/vlpd_front.sv
rtl/core/vlpd_queue.sv
rtl/core/vlpd_back.sv
rtl/core/varint_length_prefixed_deframer.sv
rtl/core/vlpd_checker.sv
tb/sv/tb.sv
